FILE: rtl/cfs_pkg.sv
`default_nettype none
package cfs_pkg;

    // Fixed formats
    localparam int SAMPLE_W   = 24;
    localparam int NUM_OUT    = 3;
    localparam int CH_W       = 2;
    localparam int GAIN_W     = 17;
    localparam int SHAPE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int SINE_DEPTH = 256;
    localparam int SINE_AW    = $clog2(SINE_DEPTH);
    localparam int DIV_STEPS  = 33;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(65536);
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Reciprocals of the Taylor divisors (2n)(2n+1), n = 1..7, scaled by
    // 2^RECIP_SHIFT; exact floor division for dividends below 2^33
    localparam int RECIP_SHIFT = 41;
    localparam longint unsigned TAYLOR_RECIP [7] = '{
        ((64'd1 << RECIP_SHIFT) + 64'd5)   / 64'd6,
        ((64'd1 << RECIP_SHIFT) + 64'd19)  / 64'd20,
        ((64'd1 << RECIP_SHIFT) + 64'd41)  / 64'd42,
        ((64'd1 << RECIP_SHIFT) + 64'd71)  / 64'd72,
        ((64'd1 << RECIP_SHIFT) + 64'd109) / 64'd110,
        ((64'd1 << RECIP_SHIFT) + 64'd155) / 64'd156,
        ((64'd1 << RECIP_SHIFT) + 64'd209) / 64'd210
    };

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_A  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_B  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_C  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_A = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_B = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_C = 3'd5;

    typedef logic [15:0] t_sine_table [SINE_DEPTH];

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_STEP, OP_SINE, OP_SHAPE, OP_GAIN,
        OP_ZERO, OP_MUL, OP_DIV, OP_SCALE, OP_OUT
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [CH_W-1:0] j;
    } t_cmd;

    typedef struct packed {
        logic            complete;
        logic            raise;
        logic            den_zero;
        logic            div_last;
        logic            out_free;
        logic [CH_W-1:0] ch;
    } t_stat;

    // Quarter sine in Q0.16 from a Q30 Taylor series, evaluated at elaboration
    function automatic t_sine_table build_sine();
        t_sine_table     tbl;
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        longint          e;
        logic [79:0]     qp;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            x    = (HALF_PI_Q30 * longint'(k)) / SINE_DEPTH;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 7; n++) begin
                term = (((term * x) >> 30) * x) >> 30;
                qp   = 80'(term) * 80'(TAYLOR_RECIP[n - 1]);
                term = 64'(qp >> RECIP_SHIFT);
                if (n % 2 == 1) sum = sum - longint'(term);
                else            sum = sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            e = (sum + 8192) >>> 14;
            if (e > 65535) e = 65535;
            tbl[k] = 16'(e);
        end
        return tbl;
    endfunction

    localparam t_sine_table SINE_TABLE = build_sine();

endpackage
`default_nettype wire

FILE: rtl/cfs_ctrl.sv
`default_nettype none
module cfs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire cfs_pkg::t_stat i_stat,
    output cfs_pkg::t_cmd      o_cmd,
    output logic               o_busy
);
    import cfs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_SINE, ST_SHAPE, ST_GAIN, ST_DECIDE,
        ST_XFER, ST_DIV, ST_SCALE, ST_OUT
    } t_state;

    localparam logic [CH_W-1:0] J_LAST = CH_W'(NUM_OUT - 1);

    t_state          r_state, n_state;
    logic [CH_W-1:0] r_j, n_j;

    assign o_busy = (r_state != ST_IDLE);

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_j      = r_j;
        o_cmd.op = OP_NONE;
        o_cmd.j  = r_j;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                o_cmd.j = i_stat.ch;
                if (i_stat.complete) begin
                    n_j     = '0;
                    n_state = ST_SCALE;
                end else begin
                    o_cmd.op = OP_STEP;
                    n_state  = ST_SINE;
                end
            end
            ST_SINE: begin
                o_cmd.j  = i_stat.ch;
                o_cmd.op = OP_SINE;
                n_state  = ST_SHAPE;
            end
            ST_SHAPE: begin
                o_cmd.j  = i_stat.ch;
                o_cmd.op = OP_SHAPE;
                n_state  = ST_GAIN;
            end
            ST_GAIN: begin
                o_cmd.j  = i_stat.ch;
                o_cmd.op = OP_GAIN;
                n_state  = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_j     = '0;
                n_state = i_stat.raise ? ST_XFER : ST_SCALE;
            end
            ST_XFER: begin
                if (r_j != i_stat.ch && !i_stat.den_zero) begin
                    o_cmd.op = OP_MUL;
                    n_state  = ST_DIV;
                end else begin
                    if (r_j != i_stat.ch) o_cmd.op = OP_ZERO;
                    n_j     = (r_j == J_LAST) ? '0 : r_j + 1'b1;
                    n_state = (r_j == J_LAST) ? ST_SCALE : ST_XFER;
                end
            end
            ST_DIV: begin
                o_cmd.op = OP_DIV;
                if (i_stat.div_last) begin
                    n_j     = (r_j == J_LAST) ? '0 : r_j + 1'b1;
                    n_state = (r_j == J_LAST) ? ST_SCALE : ST_XFER;
                end
            end
            ST_SCALE: begin
                o_cmd.op = OP_SCALE;
                n_j      = (r_j == J_LAST) ? '0 : r_j + 1'b1;
                if (r_j == J_LAST) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_j     <= n_j;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/cfs_dp.sv
`default_nettype none
module cfs_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire cfs_pkg::t_cmd                 i_cmd,
    output cfs_pkg::t_stat                     o_stat,
    input  wire logic signed [cfs_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic [cfs_pkg::CH_W-1:0]      i_channel,
    input  wire logic                          i_cfg_we,
    input  wire logic [cfs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [cfs_pkg::GAIN_W-1:0]    i_cfg_data,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic signed [cfs_pkg::SAMPLE_W-1:0] o_out [cfs_pkg::NUM_OUT]
);
    import cfs_pkg::*;

    localparam int LOW_W = 16 - SINE_AW;

    // Configuration and state
    logic [GAIN_W-1:0]         r_step  [NUM_OUT];
    logic signed [SHAPE_W-1:0] r_shape [NUM_OUT];
    logic [GAIN_W-1:0]         r_gain  [NUM_OUT];
    logic [GAIN_W-1:0]         r_pos;
    logic [CH_W-1:0]           r_last;

    // Per-item working registers
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [CH_W-1:0]            r_ch;
    logic                       r_complete;
    logic [GAIN_W-1:0]          r_sin;
    logic signed [36:0]         r_prod;
    logic                       r_raise;
    logic                       r_den_zero;
    logic [GAIN_W-1:0]          r_delta;
    logic [GAIN_W-1:0]          r_den;
    logic [32:0]                r_quo;
    logic [GAIN_W-1:0]          r_rem;
    logic [DIV_CNT_W-1:0]       r_cnt;
    logic signed [SAMPLE_W-1:0] r_res [NUM_OUT];
    logic                       r_out_valid;

    // Load: resolve selection
    logic [CH_W-1:0] ld_ch;
    always_comb begin
        ld_ch = (i_channel >= CH_W'(NUM_OUT)) ? r_last : i_channel;
    end

    // Position advance
    logic [GAIN_W:0]   pos_sum;
    logic [GAIN_W-1:0] pos_new;
    always_comb begin
        pos_sum = {1'b0, r_pos} + {1'b0, r_step[i_cmd.j]};
        if (r_step[i_cmd.j] == '0)      pos_new = UNITY;
        else if (pos_sum > {1'b0, UNITY}) pos_new = UNITY;
        else                            pos_new = pos_sum[GAIN_W-1:0];
    end

    // Sine lookup with linear interpolation
    logic [GAIN_W-1:0]  sq;
    logic [SINE_AW-1:0] s_idx;
    logic [GAIN_W-1:0]  s_a, s_b;
    logic [GAIN_W+LOW_W-1:0] s_mul;
    logic [GAIN_W-1:0]  sin_new;
    always_comb begin
        sq    = r_shape[i_cmd.j][SHAPE_W-1] ? UNITY - r_pos : r_pos;
        s_idx = sq[15 -: SINE_AW];
        s_a   = {1'b0, SINE_TABLE[s_idx]};
        s_b   = (s_idx == SINE_AW'(SINE_DEPTH - 1)) ? UNITY
                : {1'b0, SINE_TABLE[s_idx + 1'b1]};
        if (s_b < s_a) s_b = s_a;
        s_mul = (s_b - s_a) * sq[LOW_W-1:0];
        if (sq[GAIN_W-1]) sin_new = UNITY;
        else sin_new = s_a + GAIN_W'(s_mul >> LOW_W);
    end

    // Shape bend product
    logic signed [18:0] sh_d;
    logic [GAIN_W-1:0]  sh_m;
    always_comb begin
        if (!r_shape[i_cmd.j][SHAPE_W-1]) begin
            sh_d = $signed({2'b0, r_sin}) - $signed({2'b0, r_pos});
            sh_m = {1'b0, r_shape[i_cmd.j]};
        end else begin
            sh_d = $signed({2'b0, UNITY}) - $signed({2'b0, r_sin})
                   - $signed({2'b0, r_pos});
            sh_m = GAIN_W'(-$signed({r_shape[i_cmd.j][SHAPE_W-1], r_shape[i_cmd.j]}));
        end
    end

    // Target gain, clamped
    logic signed [36:0] g_sum;
    logic [GAIN_W-1:0]  g_new;
    always_comb begin
        g_sum = $signed({20'b0, r_pos}) + (r_prod >>> 15);
        if (g_sum < 0)                              g_new = '0;
        else if (g_sum > $signed({20'b0, UNITY}))   g_new = UNITY;
        else                                        g_new = g_sum[GAIN_W-1:0];
    end

    // Restoring divider step
    logic [GAIN_W:0]   dv_sh;
    logic              dv_ge;
    logic [GAIN_W-1:0] dv_rem;
    logic [32:0]       dv_quo;
    logic              dv_last;
    always_comb begin
        dv_sh   = {r_rem, r_quo[32]};
        dv_ge   = dv_sh >= {1'b0, r_den};
        dv_rem  = dv_ge ? GAIN_W'(dv_sh - {1'b0, r_den}) : dv_sh[GAIN_W-1:0];
        dv_quo  = {r_quo[31:0], dv_ge};
        dv_last = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    end

    // Output scaling with saturation
    logic [GAIN_W-1:0]          sc_g;
    logic signed [SAMPLE_W+GAIN_W:0] sc_p;
    logic signed [SAMPLE_W+GAIN_W:0] sc_v;
    logic signed [SAMPLE_W-1:0] sc_res;
    localparam logic signed [SAMPLE_W+GAIN_W:0] S_HI = (1 <<< (SAMPLE_W - 1)) - 1;
    localparam logic signed [SAMPLE_W+GAIN_W:0] S_LO = -(1 <<< (SAMPLE_W - 1));
    always_comb begin
        if (r_complete) sc_g = (i_cmd.j == r_ch) ? UNITY : '0;
        else            sc_g = r_gain[i_cmd.j];
        sc_p = r_sample * $signed({1'b0, sc_g});
        sc_v = sc_p >>> 16;
        if (sc_v > S_HI)      sc_res = S_HI[SAMPLE_W-1:0];
        else if (sc_v < S_LO) sc_res = S_LO[SAMPLE_W-1:0];
        else                  sc_res = sc_v[SAMPLE_W-1:0];
    end

    // Control state: config, position, gains, selection, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_OUT; k++) begin
                r_step[k]  <= '0;
                r_shape[k] <= '0;
                r_gain[k]  <= (k == 0) ? UNITY : '0;
            end
            r_pos       <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_STEP_A:  r_step[0]  <= i_cfg_data;
                    CFG_STEP_B:  r_step[1]  <= i_cfg_data;
                    CFG_STEP_C:  r_step[2]  <= i_cfg_data;
                    CFG_SHAPE_A: r_shape[0] <= i_cfg_data[SHAPE_W-1:0];
                    CFG_SHAPE_B: r_shape[1] <= i_cfg_data[SHAPE_W-1:0];
                    CFG_SHAPE_C: r_shape[2] <= i_cfg_data[SHAPE_W-1:0];
                    default: ;
                endcase
            end
            // Set on an output load, held while stalled, cleared after transfer
            r_out_valid <= (i_cmd.op == OP_OUT) || (r_out_valid && i_out_stall);
            case (i_cmd.op)
                OP_LOAD: begin
                    r_last <= ld_ch;
                    if (ld_ch != r_last) r_pos <= '0;
                end
                OP_STEP: r_pos <= pos_new;
                OP_GAIN: if (g_new > r_gain[i_cmd.j]) r_gain[i_cmd.j] <= g_new;
                OP_ZERO: r_gain[i_cmd.j] <= '0;
                OP_DIV: begin
                    if (dv_last) begin
                        r_gain[i_cmd.j] <= (dv_quo >= {16'b0, r_gain[i_cmd.j]}) ? '0
                                           : r_gain[i_cmd.j] - GAIN_W'(dv_quo);
                    end
                end
                default: ;
            endcase
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_sample   <= i_sample;
                r_ch       <= ld_ch;
                r_complete <= (ld_ch == r_last) && r_pos[GAIN_W-1];
            end
            OP_SINE:  r_sin  <= sin_new;
            OP_SHAPE: r_prod <= sh_d * $signed({1'b0, sh_m});
            OP_GAIN: begin
                r_raise    <= g_new > r_gain[i_cmd.j];
                r_delta    <= g_new - r_gain[i_cmd.j];
                r_den      <= UNITY - g_new;
                r_den_zero <= (g_new == UNITY);
            end
            OP_MUL: begin
                r_quo <= {16'b0, r_delta} * {16'b0, r_gain[i_cmd.j]};
                r_rem <= '0;
                r_cnt <= '0;
            end
            OP_DIV: begin
                r_quo <= dv_quo;
                r_rem <= dv_rem;
                r_cnt <= r_cnt + 1'b1;
            end
            OP_SCALE: r_res[i_cmd.j] <= sc_res;
            OP_OUT:   o_out <= r_res;
            default: ;
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.complete = r_complete;
    assign o_stat.raise    = r_raise;
    assign o_stat.den_zero = r_den_zero;
    assign o_stat.div_last = dv_last;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_stat.ch       = r_ch;

endmodule
`default_nettype wire

FILE: rtl/crossfade_output_switch.sv
// Channel  Dir  Handshake           Payload
// in       in   i_in_valid/o_in_stall   i_sample, i_channel
// out      out  o_out_valid/i_out_stall o_out_a, o_out_b, o_out_c
// cfg      in   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One sample at a time. Each input steps the position, looks up the sine, bends
// it by the shape and forms the target gain before the outputs are scaled; once
// the fade is complete it goes straight to scaling. When a fade raises the selected
// gain, each other output adds a multiply and 33 divider steps, or a clear if the divisor is zero.
// Synchronous active-low reset restores gains (A at one) and clears config.
// A finished result waits in the output register while the next sample
// is taken; the sequencer holds before its output load until that slot frees.
`default_nettype none
module crossfade_output_switch (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [cfs_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic [cfs_pkg::CH_W-1:0]      i_channel,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [cfs_pkg::SAMPLE_W-1:0] o_out_a,
    output logic signed [cfs_pkg::SAMPLE_W-1:0] o_out_b,
    output logic signed [cfs_pkg::SAMPLE_W-1:0] o_out_c,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [cfs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [cfs_pkg::GAIN_W-1:0]    i_cfg_data
);
    import cfs_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  busy;
    logic signed [SAMPLE_W-1:0] outs [NUM_OUT];

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = busy;
    assign o_out_a     = outs[0];
    assign o_out_b     = outs[1];
    assign o_out_c     = outs[2];

    cfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    cfs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_sample    (i_sample),
        .i_channel   (i_channel),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (outs)
    );

    // A transfer in always starts a busy period
    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("no busy after input transfer");

    // The output register is loaded only when its slot is free
    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_OUT) |-> (!o_out_valid || !i_out_stall))
        else $error("output overwritten while stalled");

    // A new result follows an output load
    a_out_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_OUT) |=> o_out_valid)
        else $error("output valid missing after load");

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cfs_pkg::*;

    // Channel codes on i_channel
    localparam logic [CH_W-1:0] CH_A   = 2'd0;
    localparam logic [CH_W-1:0] CH_B   = 2'd1;
    localparam logic [CH_W-1:0] CH_C   = 2'd2;
    localparam logic [CH_W-1:0] CH_BAD = 2'd3;
    // Register indexes past the last real register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
    localparam longint FULL = 65536;
    localparam int     SETTLE_CYCLES = 120;

    typedef struct {
        logic signed [SAMPLE_W-1:0] v [NUM_OUT];
    } t_mix;

    // Scoreboard: crossfade predictor plus queue of expected output triples
    class crossfade_board;
        longint        step_q16 [NUM_OUT];
        longint        shape_q15 [NUM_OUT];
        longint        gain [NUM_OUT];
        longint        position;
        int unsigned   sel;
        longint        sine [SINE_DEPTH];
        t_mix          pending_mix [$];
        int            errors;
        int            checked;
        int            switches;

        function new();
            longint unsigned x, term;
            longint sum, e;
            for (int k = 0; k < SINE_DEPTH; k++) begin
                x    = (HALF_PI_Q30 * longint'(k)) / SINE_DEPTH;
                term = x;
                sum  = longint'(x);
                for (int n = 1; n <= 7; n++) begin
                    term = (((term * x) >> 30) * x) >> 30;
                    term = term / longint'((2 * n) * (2 * n + 1));
                    sum  = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
                end
                if (sum < 0) sum = 0;
                e = (sum + 8192) >>> 14;
                sine[k] = (e > 65535) ? 65535 : e;
            end
            for (int j = 0; j < NUM_OUT; j++) begin
                step_q16[j]  = 0;
                shape_q15[j] = 0;
                gain[j]      = (j == 0) ? FULL : 0;
            end
            position = 0;
            sel      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
            case (idx)
                CFG_STEP_A:  step_q16[0] = data;
                CFG_STEP_B:  step_q16[1] = data;
                CFG_STEP_C:  step_q16[2] = data;
                CFG_SHAPE_A: shape_q15[0] = longint'($signed(data[15:0]));
                CFG_SHAPE_B: shape_q15[1] = longint'($signed(data[15:0]));
                CFG_SHAPE_C: shape_q15[2] = longint'($signed(data[15:0]));
                default: ;
            endcase
        endfunction

        // Interpolated quarter sine, position in Q1.16
        function longint sine_at(longint p);
            longint t, idx, frac, a, b;
            if (p >= FULL) return FULL;
            t    = p * SINE_DEPTH;
            idx  = t >> 16;
            frac = t & 16'hFFFF;
            a    = sine[idx];
            b    = (idx + 1 < SINE_DEPTH) ? sine[idx + 1] : FULL;
            if (b < a) b = a;
            return a + (((b - a) * frac) >> 16);
        endfunction

        function logic signed [SAMPLE_W-1:0] scaled(longint s, longint g);
            longint v;
            v = (s * g) >>> 16;
            if (v > 8388607) v = 8388607;
            if (v < -8388608) v = -8388608;
            return v[SAMPLE_W-1:0];
        endfunction

        function void note_input(logic signed [SAMPLE_W-1:0] smp, logic [CH_W-1:0] chin);
            int unsigned ch;
            longint s, d, m, g, delta, den, take;
            t_mix e;
            s  = smp;
            ch = (chin >= NUM_OUT) ? sel : chin;
            if (ch != sel) begin
                position = 0;
                switches++;
            end
            sel = ch;
            if (position >= FULL) begin
                // fade done: straight pass on the selected output
                for (int j = 0; j < NUM_OUT; j++)
                    e.v[j] = (j == ch) ? scaled(s, FULL) : '0;
            end else begin
                if (step_q16[ch] > 0)
                    position = (position + step_q16[ch] > FULL) ? FULL
                               : position + step_q16[ch];
                else
                    position = FULL;
                if (shape_q15[ch] >= 0) begin
                    d = sine_at(position) - position;
                    m = shape_q15[ch];
                end else begin
                    d = FULL - sine_at(FULL - position) - position;
                    m = -shape_q15[ch];
                end
                g = position + ((d * m) >>> 15);
                if (g < 0) g = 0;
                if (g > FULL) g = FULL;
                // gain only rises; others give up share in proportion
                if (g > gain[ch]) begin
                    delta    = g - gain[ch];
                    den      = FULL - g;
                    gain[ch] = g;
                    for (int j = 0; j < NUM_OUT; j++) begin
                        if (j == ch) continue;
                        if (den == 0) begin
                            gain[j] = 0;
                        end else begin
                            take    = (delta * gain[j]) / den;
                            gain[j] = (take >= gain[j]) ? 0 : gain[j] - take;
                            if (gain[j] > FULL) gain[j] = FULL;
                        end
                    end
                end
                for (int j = 0; j < NUM_OUT; j++)
                    e.v[j] = scaled(s, gain[j]);
            end
            pending_mix.push_back(e);
        endfunction

        function void check_result(logic signed [SAMPLE_W-1:0] a,
                                   logic signed [SAMPLE_W-1:0] b,
                                   logic signed [SAMPLE_W-1:0] c);
            logic signed [SAMPLE_W-1:0] got [NUM_OUT];
            string nm;
            t_mix e;
            got = '{a, b, c};
            nm  = "abc";
            checked++;
            if (pending_mix.size() == 0) begin
                $display("%0t: result with nothing expected: %0d %0d %0d", $realtime, a, b, c);
                errors++;
                return;
            end
            e = pending_mix.pop_front();
            for (int j = 0; j < NUM_OUT; j++)
                if (got[j] !== e.v[j]) begin
                    $display("%0t: out_%c expected %0d actual %0d",
                             $realtime, nm[j], e.v[j], got[j]);
                    errors++;
                end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic [CH_W-1:0]        i_channel;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic signed [SAMPLE_W-1:0] o_out_a, o_out_b, o_out_c;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [GAIN_W-1:0]      i_cfg_data;

    crossfade_board board = new();
    int burst_left;
    int stall_mode;
    int rx_cycle;

    crossfade_output_switch dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("tb_top failed");
        $finish;
    end

    // Output side: check each transfer, stall on a changing pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_result(o_out_a, o_out_b, o_out_c);
        rx_cycle++;
        if (rx_cycle % 256 == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= 1'($urandom_range(0, 1));
            default: i_out_stall <= (rx_cycle % 32) < 20;
        endcase
    end

    // One register write, then valid is dropped on the config channel
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sender works in bursts with random gaps
    task automatic send(logic signed [SAMPLE_W-1:0] smp, logic [CH_W-1:0] ch);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_sample   <= smp;
        i_channel  <= ch;
        do @(posedge i_clk); while (o_in_stall);
        board.note_input(smp, ch);
    endtask

    // Hold the sender until all results are back, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending_mix.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [GAIN_W-1:0] pick_step();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return GAIN_W'(FULL);
            2:       return GAIN_W'($urandom_range(1, 600));
            3:       return GAIN_W'($urandom_range(600, 8000));
            default: return GAIN_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_shape();
        case ($urandom_range(0, 4))
            0:       return GAIN_W'(16'h7FFF);
            1:       return GAIN_W'(16'h8000);
            2:       return '0;
            default: return GAIN_W'($urandom());
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 24'sh7FFFFF;
            1:       return 24'sh800000;
            2:       return '0;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    initial begin
        logic [CH_W-1:0] ch;
        int run;
        int sent;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_sample    <= '0;
        i_channel   <= CH_A;
        i_out_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_STEP_A;
        i_cfg_data  <= '0;
        burst_left  = 0;
        stall_mode  = 0;
        rx_cycle    = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset config: every switch is instant
        send(24'sh7FFFFF, CH_A);
        send(24'sh800000, CH_A);
        send(24'sh000001, CH_B);
        send(24'sh800000, CH_B);
        send(24'sh7FFFFF, CH_BAD);
        send(24'sh123456, CH_C);
        drain();

        // Full step, strongest positive and negative bends, slow fades
        write_reg(CFG_STEP_A, GAIN_W'(FULL));
        write_reg(CFG_STEP_B, GAIN_W'(9000));
        write_reg(CFG_STEP_C, GAIN_W'(20000));
        write_reg(CFG_SHAPE_A, GAIN_W'(16'h7FFF));
        write_reg(CFG_SHAPE_B, GAIN_W'(16'h8000));
        write_reg(CFG_SHAPE_C, '0);
        write_reg(CFG_SPARE_6, '1);
        write_reg(CFG_SPARE_7, GAIN_W'(1234));
        for (int k = 0; k < 9; k++) send(k[0] ? 24'sh7FFFFF : 24'sh800000, CH_B);
        send(24'sh400000, CH_C);
        send(24'sh400000, CH_BAD);
        send(24'sh7FFFFF, CH_C);
        send(24'sh7FFFFF, CH_C);
        send(24'sh7FFFFF, CH_C);
        send(24'sh800000, CH_A);
        send(24'sh000000, CH_A);
        drain();

        // Random phases: new settings, then fades of random length
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_STEP_A, pick_step());
            write_reg(CFG_STEP_B, pick_step());
            write_reg(CFG_STEP_C, pick_step());
            write_reg(CFG_SHAPE_A, pick_shape());
            write_reg(CFG_SHAPE_B, pick_shape());
            write_reg(CFG_SHAPE_C, pick_shape());
            if ($urandom_range(0, 1)) write_reg(CFG_SPARE_7, GAIN_W'($urandom()));
            sent = 0;
            while (sent < 150) begin
                ch  = CH_W'($urandom_range(0, 2));
                run = $urandom_range(0, 4) == 0 ? $urandom_range(1, 3)
                                                : $urandom_range(4, 60);
                for (int k = 0; k < run && sent < 150; k++) begin
                    send(pick_sample(), $urandom_range(0, 15) == 0 ? CH_BAD : ch);
                    sent++;
                end
            end
            drain();
        end

        $display("Checked %0d output triples over %0d selection changes, %0d mismatches.",
                 board.checked, board.switches, board.errors);
        if (board.errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
